[src/sst_pkg.sv]
// Shared types and constants for the sparse set table.
`default_nettype none
package sst_pkg;

  // Number of table entries; the value and mask fields are sized for it.
  localparam int CAPACITY = 32;
  localparam int IDX_W    = 5;
  localparam int CNT_W    = 6;

  // Operation codes.
  localparam logic [3:0] MODE_INSERT     = 4'd0;
  localparam logic [3:0] MODE_REMOVE     = 4'd1;
  localparam logic [3:0] MODE_TEST       = 4'd2;
  localparam logic [3:0] MODE_GET_FIRST  = 4'd3;
  localparam logic [3:0] MODE_CLEAR      = 4'd4;
  localparam logic [3:0] MODE_FILL       = 4'd5;
  localparam logic [3:0] MODE_CONTAINS   = 4'd6;
  localparam logic [3:0] MODE_INTERSECTS = 4'd7;
  localparam logic [3:0] MODE_EQUALS     = 4'd8;

  // Status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_RANGE     = 2'd1;
  localparam logic [1:0] STATUS_EMPTY_GET = 2'd2;

  typedef logic [CNT_W-1:0] limit_t;

  typedef struct packed {
    logic [3:0]       mode;
    logic [IDX_W-1:0] value;
    logic [31:0]      other_mask;
  } sst_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             changed;
    logic             answer;
    logic [IDX_W-1:0] first_element;
    logic [CNT_W-1:0] element_count;
    logic [31:0]      member_bits;
  } sst_out_t;

endpackage
`default_nettype wire

[src/sst_chan_if.sv]
// Valid/ready channel interface carrying one payload item.
`default_nettype none
interface sst_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/sst_engine.sv]
// Set state (mask, count, dense list, position table) and its update on each accepted item.
`default_nettype none
module sst_engine (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire sst_pkg::sst_in_t item,
  input  wire sst_pkg::limit_t  limit,
  output sst_pkg::sst_out_t     result
);

  logic [31:0]                  mask_r, mask_nxt;
  logic [sst_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [sst_pkg::IDX_W-1:0]    dense_r [sst_pkg::CAPACITY];
  logic [sst_pkg::IDX_W-1:0]    pos_r   [sst_pkg::CAPACITY];

  logic [sst_pkg::CNT_W-1:0]    lim;
  logic [sst_pkg::CNT_W-1:0]    count_m1;
  logic                         in_range;
  logic                         member;
  logic [sst_pkg::IDX_W-1:0]    top_val;
  logic [sst_pkg::IDX_W-1:0]    free_pos;
  logic [31:0]                  fill_mask;
  logic                         ins_we, rm_we, fill_we;

  // Effective limit is clamped to the table size.
  always_comb begin
    if (limit > sst_pkg::CNT_W'(sst_pkg::CAPACITY)) begin
      lim = sst_pkg::CNT_W'(sst_pkg::CAPACITY);
    end else begin
      lim = limit;
    end
  end

  assign count_m1 = count_r - sst_pkg::CNT_W'(1);
  assign in_range = {1'b0, item.value} < lim;
  assign member   = mask_r[item.value];
  assign top_val  = dense_r[count_m1[sst_pkg::IDX_W-1:0]];
  assign free_pos = pos_r[item.value];

  // Mask of all values below the limit, used by fill.
  always_comb begin
    for (int i = 0; i < 32; i++) begin
      fill_mask[i] = sst_pkg::CNT_W'(i) < lim;
    end
  end

  // Per-operation next state and result fields.
  always_comb begin
    mask_nxt             = mask_r;
    count_nxt            = count_r;
    ins_we               = 1'b0;
    rm_we                = 1'b0;
    fill_we              = 1'b0;
    result.status        = sst_pkg::STATUS_OK;
    result.changed       = 1'b0;
    result.answer        = 1'b0;
    result.first_element = '0;
    case (item.mode)
      sst_pkg::MODE_INSERT: begin
        if (!in_range) begin
          result.status = sst_pkg::STATUS_RANGE;
        end else if (!member && (count_r < sst_pkg::CNT_W'(sst_pkg::CAPACITY))) begin
          ins_we                = 1'b1;
          count_nxt             = count_r + sst_pkg::CNT_W'(1);
          mask_nxt[item.value]  = 1'b1;
          result.changed        = 1'b1;
        end
      end
      sst_pkg::MODE_REMOVE: begin
        if (!in_range) begin
          result.status = sst_pkg::STATUS_RANGE;
        end else if (member && (count_r != '0)) begin
          rm_we                 = 1'b1;
          count_nxt             = count_m1;
          mask_nxt[item.value]  = 1'b0;
          result.changed        = 1'b1;
        end
      end
      sst_pkg::MODE_TEST: begin
        if (!in_range) begin
          result.status = sst_pkg::STATUS_RANGE;
        end else begin
          result.answer = member;
        end
      end
      sst_pkg::MODE_GET_FIRST: begin
        if (count_r == '0) begin
          result.status = sst_pkg::STATUS_EMPTY_GET;
        end else begin
          result.first_element = dense_r[0];
        end
      end
      sst_pkg::MODE_CLEAR: begin
        count_nxt = '0;
        mask_nxt  = '0;
      end
      sst_pkg::MODE_FILL: begin
        if (count_r < lim) begin
          fill_we   = 1'b1;
          count_nxt = lim;
          mask_nxt  = fill_mask;
        end
      end
      sst_pkg::MODE_CONTAINS: begin
        result.answer = (item.other_mask & ~mask_r) == '0;
      end
      sst_pkg::MODE_INTERSECTS: begin
        result.answer = (item.other_mask & mask_r) != '0;
      end
      sst_pkg::MODE_EQUALS: begin
        result.answer = mask_r == item.other_mask;
      end
      default: begin
      end
    endcase
    result.element_count = count_nxt;
    result.member_bits   = mask_nxt;
  end

  // Mask and count carry the reset state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '0;
      count_r <= '0;
    end else if (fire) begin
      mask_r  <= mask_nxt;
      count_r <= count_nxt;
    end
  end

  // Table writes: fill rewrites every entry below the limit, insert appends,
  // remove moves the last list entry into the freed slot.
  always_ff @(posedge clk) begin
    if (fire) begin
      if (fill_we) begin
        for (int i = 0; i < sst_pkg::CAPACITY; i++) begin
          if (sst_pkg::CNT_W'(i) < lim) begin
            dense_r[i] <= sst_pkg::IDX_W'(i);
            pos_r[i]   <= sst_pkg::IDX_W'(i);
          end
        end
      end else if (ins_we) begin
        dense_r[count_r[sst_pkg::IDX_W-1:0]] <= item.value;
        pos_r[item.value]                    <= count_r[sst_pkg::IDX_W-1:0];
      end else if (rm_we) begin
        dense_r[free_pos] <= top_val;
        pos_r[top_val]    <= free_pos;
      end
    end
  end

endmodule
`default_nettype wire

[src/sparse_set_table_core.sv]
// Top level of the sparse set table: channel registers and the limit register.
`default_nettype none
// The block keeps a set of values 0..31 as a dense list, a position table
// and a membership mask, all in flip-flops, and performs one operation per
// item: insert, remove, test, get first, clear, fill or a mask comparison. It
// accepts one item per clock cycle while the result channel does not stall.
// An item passes through the input register and then the result register,
// from which its result leaves. The rate is set by the update of the flip-flop
// tables, which sits between the input register and the result register. Write
// the limit only while no item is in flight; the write channel is always ready.
module sparse_set_table_core (
  input  wire logic clk,
  input  wire logic rst_n,
  sst_chan_if.sink   in_chan,
  sst_chan_if.source out_chan,
  sst_chan_if.sink   cfg_chan
);

  logic              in_vld_r;
  sst_pkg::sst_in_t  in_item_r;
  logic              out_vld_r;
  sst_pkg::sst_out_t out_item_r;
  sst_pkg::limit_t   limit_r;
  sst_pkg::sst_out_t result;
  logic              advance;

  // Work proceeds when the result register is free or being drained.
  assign advance       = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || advance;
  assign cfg_chan.ready = 1'b1;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_item_r <= in_chan.data;
    end
  end

  // Limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= sst_pkg::CNT_W'(sst_pkg::CAPACITY);
    end else if (cfg_chan.valid) begin
      limit_r <= cfg_chan.data;
    end
  end

  sst_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (in_item_r),
    .limit  (limit_r),
    .result (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_chan.valid = out_vld_r;
  assign out_chan.data  = out_item_r;

endmodule
`default_nettype wire
